// File: hw/rtl/hred_pkg.sv
// types and constants shared by the http request end detector modules
// no dependencies
`timescale 1ns / 1ps

package hred_pkg;

	localparam int NAME_LEN = 15;
	localparam int QDEPTH   = 2;
	localparam logic [23:0] MAX_LENGTH_RESET = 24'd1048576;

	localparam logic [7:0] CHAR_CR    = 8'h0d;
	localparam logic [7:0] CHAR_LF    = 8'h0a;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;

	// "content-length:" in lower case
	localparam logic [7:0] NAME_TEXT [NAME_LEN] = '{
		8'h63, 8'h6f, 8'h6e, 8'h74, 8'h65, 8'h6e, 8'h74, 8'h2d,
		8'h6c, 8'h65, 8'h6e, 8'h67, 8'h74, 8'h68, 8'h3a
	};

	typedef enum logic [1:0] {
		PH_SEARCH = 2'd0,
		PH_SKIP   = 2'd1,
		PH_DIGITS = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	// one classified byte, passed from front to back
	typedef struct packed {
		logic        first;
		logic        is_cr;
		logic        is_lf;
		logic        is_digit;
		logic        is_blank;
		logic [3:0]  digit_val;
		logic [15:0] name_hit;   // bit i: folded byte equals name character i
	} class_t;

endpackage

// File: hw/rtl/hred_front.sv
// front stage: accepts request bytes and classifies them into class_t
// depends on hred_pkg
`timescale 1ns / 1ps

module hred_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           data_byte,
	input  logic                 first,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 push,
	output hred_pkg::class_t     push_data,
	input  logic                 q_full
);
	import hred_pkg::*;

	logic       valid_s1;
	class_t     class_s1;
	class_t     class_c;
	logic [7:0] folded;
	logic       advance;

	always_comb begin
		folded = data_byte;
		if (data_byte >= CHAR_UPPER_A && data_byte <= CHAR_UPPER_Z) begin
			folded = data_byte + 8'd32;
		end
		class_c.first     = first;
		class_c.is_cr     = (data_byte == CHAR_CR);
		class_c.is_lf     = (data_byte == CHAR_LF);
		class_c.is_digit  = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
		class_c.is_blank  = (data_byte == CHAR_SPACE) || (data_byte == CHAR_TAB);
		class_c.digit_val = data_byte[3:0];
		class_c.name_hit  = '0;
		for (int i = 0; i < NAME_LEN; i++) begin
			class_c.name_hit[i] = (folded == NAME_TEXT[i]);
		end
	end

	assign push      = valid_s1 && !q_full;
	assign push_data = class_s1;
	assign advance   = !valid_s1 || !q_full;
	assign in_ready  = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			class_s1 <= class_c;
		end
	end

endmodule

// File: hw/rtl/hred_queue.sv
// two-entry queue of classified bytes between front and back
// depends on hred_pkg
`timescale 1ns / 1ps

module hred_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  hred_pkg::class_t     push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 empty,
	output hred_pkg::class_t     pop_data
);
	import hred_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	class_t        mem_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;
	logic          do_push;
	logic          do_pop;

	assign full     = (count_q == (PW+1)'(QDEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: hw/rtl/hred_back.sv
// back stage: request state update per byte and the result register
// depends on hred_pkg
`timescale 1ns / 1ps

module hred_back #(
	parameter int LENGTH_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [23:0]          cfg_data,
	input  logic                 q_empty,
	input  hred_pkg::class_t     q_data,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          out_data
);
	import hred_pkg::*;

	localparam int LB = LENGTH_BITS;

	logic [23:0]   max_q;
	logic [1:0]    blank_q;
	logic [3:0]    idx_q;
	phase_t        phase_q;
	logic [LB-1:0] dl_q;
	logic [LB-1:0] bc_q;
	logic          hdr_q;
	logic          ov_q;

	logic [1:0]    cur_blank, nx_blank;
	logic [3:0]    cur_idx, nx_idx, hit_idx;
	phase_t        cur_ph, nx_ph;
	logic [LB-1:0] cur_dl, nx_dl, cur_bc, nx_bc;
	logic          cur_hdr, nx_hdr, cur_ov, nx_ov;
	logic [LB+3:0] next_len;
	logic [LB+23:0] max_ext;
	logic [LB-1:0] max_len;
	logic [LB+23:0] dl_ext;
	logic          nx_complete;

	logic          out_valid_q;
	logic [31:0]   out_data_q;

	assign pop       = !q_empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign max_ext = {{LB{1'b0}}, max_q};
	assign max_len = max_ext[LB-1:0];

	always_comb begin
		// a first byte starts from cleared state
		cur_blank = q_data.first ? 2'd0 : blank_q;
		cur_idx   = q_data.first ? 4'd0 : idx_q;
		cur_ph    = q_data.first ? PH_SEARCH : phase_q;
		cur_dl    = q_data.first ? '0 : dl_q;
		cur_bc    = q_data.first ? '0 : bc_q;
		cur_hdr   = q_data.first ? 1'b0 : hdr_q;
		cur_ov    = q_data.first ? 1'b0 : ov_q;

		nx_blank = cur_blank;
		nx_idx   = cur_idx;
		nx_ph    = cur_ph;
		nx_dl    = cur_dl;
		nx_bc    = cur_bc;
		nx_hdr   = cur_hdr;
		nx_ov    = cur_ov;
		next_len = ({4'b0, cur_dl} << 3) + ({4'b0, cur_dl} << 1)
			+ {{LB{1'b0}}, q_data.digit_val};
		hit_idx  = '0;

		if (cur_hdr) begin
			if (cur_bc != {LB{1'b1}}) begin
				nx_bc = cur_bc + 1'b1;
			end
		end else begin
			unique case (cur_ph)
				PH_SKIP: begin
					if (q_data.is_blank) begin
						nx_ph = PH_SKIP;
					end else if (q_data.is_digit) begin
						nx_ph = PH_DIGITS;
					end else begin
						nx_ph = PH_DONE;
					end
				end
				PH_DIGITS: begin
					if (!q_data.is_digit) begin
						nx_ph = PH_DONE;
					end
				end
				PH_SEARCH, PH_DONE: begin
					nx_ph = cur_ph;
				end
				default: nx_ph = cur_ph;
			endcase

			if (nx_ph == PH_DIGITS && q_data.is_digit) begin
				if (next_len > {4'b0, max_len}) begin
					nx_dl = max_len;
					nx_ov = 1'b1;
					nx_ph = PH_DONE;
				end else begin
					nx_dl = next_len[LB-1:0];
				end
			end

			if (nx_ph == PH_SEARCH) begin
				if (q_data.name_hit[cur_idx]) begin
					hit_idx = cur_idx + 1'b1;
				end else begin
					hit_idx = q_data.name_hit[0] ? 4'd1 : 4'd0;
				end
				if (hit_idx == 4'(NAME_LEN)) begin
					nx_idx = 4'd0;
					nx_ph  = PH_SKIP;
				end else begin
					nx_idx = hit_idx;
				end
			end

			// blank line search for cr lf cr lf
			unique case (cur_blank)
				2'd0: nx_blank = q_data.is_cr ? 2'd1 : 2'd0;
				2'd1: nx_blank = q_data.is_lf ? 2'd2 : (q_data.is_cr ? 2'd1 : 2'd0);
				2'd2: nx_blank = q_data.is_cr ? 2'd3 : 2'd0;
				2'd3: begin
					if (q_data.is_lf) begin
						nx_hdr   = 1'b1;
						nx_blank = 2'd0;
					end else begin
						nx_blank = q_data.is_cr ? 2'd1 : 2'd0;
					end
				end
				default: nx_blank = 2'd0;
			endcase
		end

		nx_complete = nx_hdr && (nx_ph == PH_SEARCH || nx_ov || nx_bc >= nx_dl);
	end

	assign dl_ext = {24'b0, nx_dl};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q       <= MAX_LENGTH_RESET;
			blank_q     <= 2'd0;
			idx_q       <= 4'd0;
			phase_q     <= PH_SEARCH;
			dl_q        <= '0;
			bc_q        <= '0;
			hdr_q       <= 1'b0;
			ov_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_data;
			end
			if (pop) begin
				blank_q <= nx_blank;
				idx_q   <= nx_idx;
				phase_q <= nx_ph;
				dl_q    <= nx_dl;
				bc_q    <= nx_bc;
				hdr_q   <= nx_hdr;
				ov_q    <= nx_ov;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= {4'b0, nx_ov, dl_ext[23:0], (nx_ph != PH_SEARCH), nx_hdr,
				nx_complete};
		end
	end

endmodule

// File: hw/rtl/http_request_end_detector_top.sv
// top level of the http request end detector: front, queue and back
// depends on hred_pkg, hred_front, hred_queue, hred_back
`timescale 1ns / 1ps

// Takes an HTTP request one byte per transaction (s_tuser marks the first byte
// of a new request) and returns one result transaction per byte telling whether
// the request is complete: header ended at the first CR LF CR LF and, when a
// content-length header was found, the body byte count reached the declared
// length (lengths above max_length saturate, set too_long and complete at
// header end). One byte is taken every cycle unless the queue is full and
// s_tready is low. A byte passes through the classify register, the queue and
// the state update into the result register. max_length is written through
// cfg_we / cfg_data; the user must write it only while the block is idle (the
// block itself does not enforce this), and it resets to 1048576.

module http_request_end_detector_top #(
	parameter int LENGTH_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [23:0] cfg_data,      // max_length
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,       // [7:0] data_byte
	input  logic        s_tuser,       // [0] first
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata        // [0] complete, [1] header_done, [2] length_found,
	                                   // [26:3] body_length, [27] too_long, [31:28] zero
);
	import hred_pkg::*;

	logic   push;
	class_t push_data;
	logic   q_full;
	logic   pop;
	logic   q_empty;
	class_t q_data;

	hred_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (s_tdata),
		.first     (s_tuser),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	hred_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.pop_data  (q_data)
	);

	hred_back #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

// File: verif/http_request_end_detector_top_tb.sv
// self-checking testbench for the http request end detector top level
// depends on hred_pkg and http_request_end_detector_top
`timescale 1ns / 1ps

module http_request_end_detector_top_tb;

	import hred_pkg::*;

	// result fields, highest bit first as on m_tdata
	typedef struct packed {
		logic        too_long;
		logic [23:0] body_length;
		logic        length_found;
		logic        header_done;
		logic        complete;
	} status_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [23:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;

	bit gaps_on = 1'b1;
	int err_count;
	int bytes_sent;
	int result_idx;

	status_t pending_status[$];
	status_t got_status;
	status_t want_status;

	// tracker state for the request being parsed
	logic [1:0]  blank_stage;
	logic [3:0]  match_idx;
	phase_t      phase;
	logic [23:0] declared;
	logic [23:0] body_cnt;
	logic [23:0] max_len;
	logic        hdr_seen;
	logic        ovf_seen;

	http_request_end_detector_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic void clear_tracker();
		blank_stage = 2'd0;
		match_idx   = 4'd0;
		phase       = PH_SEARCH;
		declared    = 24'd0;
		body_cnt    = 24'd0;
		hdr_seen    = 1'b0;
		ovf_seen    = 1'b0;
	endfunction

	// advances the tracker by one byte and returns the status after it
	function automatic status_t track_byte(input logic [7:0] b, input logic f);
		logic        is_digit;
		logic [7:0]  c;
		int          idx;
		logic [31:0] next_len;
		status_t     st;
		if (f)
			clear_tracker();
		if (hdr_seen) begin
			if (body_cnt != 24'hffffff)
				body_cnt = body_cnt + 24'd1;
		end else begin
			is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
			if (phase == PH_SKIP) begin
				if (!(b == CHAR_SPACE || b == CHAR_TAB))
					phase = is_digit ? PH_DIGITS : PH_DONE;
			end else if (phase == PH_DIGITS && !is_digit) begin
				phase = PH_DONE;
			end
			if (phase == PH_DIGITS && is_digit) begin
				next_len = {8'd0, declared} * 32'd10 + 32'(b - CHAR_ZERO);
				if (next_len > {8'd0, max_len}) begin
					declared = max_len;
					ovf_seen = 1'b1;
					phase    = PH_DONE;
				end else begin
					declared = next_len[23:0];
				end
			end
			if (phase == PH_SEARCH) begin
				c   = (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ? b + 8'd32 : b;
				idx = match_idx;
				if (idx < NAME_LEN && c == NAME_TEXT[idx])
					idx++;
				else
					idx = (c == NAME_TEXT[0]) ? 1 : 0;
				if (idx >= NAME_LEN) begin
					match_idx = 4'd0;
					phase     = PH_SKIP;
				end else begin
					match_idx = 4'(idx);
				end
			end
			case (blank_stage)
				2'd0: blank_stage = (b == CHAR_CR) ? 2'd1 : 2'd0;
				2'd1: blank_stage = (b == CHAR_LF) ? 2'd2 : ((b == CHAR_CR) ? 2'd1 : 2'd0);
				2'd2: blank_stage = (b == CHAR_CR) ? 2'd3 : 2'd0;
				default: begin
					if (b == CHAR_LF) begin
						hdr_seen    = 1'b1;
						blank_stage = 2'd0;
					end else begin
						blank_stage = (b == CHAR_CR) ? 2'd1 : 2'd0;
					end
				end
			endcase
		end
		st.complete     = hdr_seen && (phase == PH_SEARCH || ovf_seen || body_cnt >= declared);
		st.header_done  = hdr_seen;
		st.length_found = (phase != PH_SEARCH);
		st.body_length  = declared;
		st.too_long     = ovf_seen;
		return st;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] want);
		$display("mismatch in %s at result %0d: got %0h, expected %0h",
		         what, result_idx, got, want);
		err_count++;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_status = status_t'(m_tdata[27:0]);
			if (pending_status.size() == 0) begin
				report_mismatch("unexpected transaction", m_tdata, 32'd0);
			end else begin
				want_status = pending_status.pop_front();
				if (got_status.complete !== want_status.complete)
					report_mismatch("complete", 32'(got_status.complete),
					                32'(want_status.complete));
				if (got_status.header_done !== want_status.header_done)
					report_mismatch("header_done", 32'(got_status.header_done),
					                32'(want_status.header_done));
				if (got_status.length_found !== want_status.length_found)
					report_mismatch("length_found", 32'(got_status.length_found),
					                32'(want_status.length_found));
				if (got_status.body_length !== want_status.body_length)
					report_mismatch("body_length", 32'(got_status.body_length),
					                32'(want_status.body_length));
				if (got_status.too_long !== want_status.too_long)
					report_mismatch("too_long", 32'(got_status.too_long),
					                32'(want_status.too_long));
			end
			result_idx++;
		end
	end

	// receiver backpressure
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (gaps_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic f);
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= f;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_status.push_back(track_byte(b, f));
		bytes_sent++;
	endtask

	task automatic send_text(input string s, input bit first_on_start);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], first_on_start && i == 0);
	endtask

	task automatic send_crlf();
		send_byte(CHAR_CR, 1'b0);
		send_byte(CHAR_LF, 1'b0);
	endtask

	// stop sending and wait for every outstanding result
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
	endtask

	task automatic set_max_length(input logic [23:0] v);
		settle();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		max_len = v;
	endtask

	// content-length line with random case, blanks and value; returns a body size
	task automatic send_length_header(output int body_hint);
		logic [7:0] c;
		string      digits;
		int         mode;
		int         val;
		if ($urandom_range(0, 6) == 0)
			send_text("x-", 1'b0);
		for (int i = 0; i < NAME_LEN; i++) begin
			c = NAME_TEXT[i];
			if (c >= CHAR_UPPER_A + 8'd32 && c <= CHAR_UPPER_Z + 8'd32 && $urandom_range(0, 1))
				c = c - 8'd32;
			send_byte(c, 1'b0);
		end
		repeat ($urandom_range(0, 2))
			send_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB, 1'b0);
		mode = $urandom_range(0, 9);
		if (mode == 0) begin
			// no digits at all
			if ($urandom_range(0, 1))
				send_text("x", 1'b0);
			body_hint = 0;
		end else if (mode < 3) begin
			digits = "";
			repeat ($urandom_range(1, 9))
				digits = {digits, $sformatf("%0d", $urandom_range(0, 9))};
			send_text(digits, 1'b0);
			body_hint = 40;
		end else begin
			val = $urandom_range(0, 24);
			send_text($sformatf("%0d", val), 1'b0);
			body_hint = val;
		end
		send_crlf();
	endtask

	task automatic send_random_request();
		int  hint;
		int  n_hdr;
		int  cl_pos;
		int  n_body;
		bit  fresh;
		bit  has_cl;
		if ($urandom_range(0, 99) < 12) begin
			// noise, with stray request starts
			repeat ($urandom_range(1, 24))
				send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
			return;
		end
		fresh  = ($urandom_range(0, 9) != 0);
		has_cl = ($urandom_range(0, 9) < 7);
		hint   = $urandom_range(0, 3);
		n_hdr  = $urandom_range(0, 2);
		cl_pos = $urandom_range(0, n_hdr);
		send_text("GET /", fresh);
		repeat ($urandom_range(0, 4))
			send_byte(8'($urandom_range(8'h21, 8'h7e)), 1'b0);
		send_crlf();
		for (int i = 0; i <= n_hdr; i++) begin
			if (i == cl_pos && has_cl) begin
				send_length_header(hint);
			end else begin
				// near miss on the header name now and then
				if ($urandom_range(0, 2) == 0)
					send_text("Content-Type: ", 1'b0);
				else
					send_text("Host: ", 1'b0);
				repeat ($urandom_range(0, 4))
					send_byte(8'($urandom_range(8'h21, 8'h7e)), 1'b0);
				send_crlf();
			end
		end
		if (has_cl && $urandom_range(0, 9) == 0)
			send_length_header(n_body);
		if ($urandom_range(0, 19) == 0)
			return;
		send_crlf();
		n_body = ($urandom_range(0, 9) == 0) ? $urandom_range(0, hint) : hint + $urandom_range(0, 2);
		repeat (n_body)
			send_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	task automatic test_basic_requests();
		// folded name, mixed blanks, body bytes past completion
		send_text("GET / HTTP/1.1", 1'b1);
		send_crlf();
		send_text("CONTENT-lengtH: \t3", 1'b0);
		send_crlf();
		send_crlf();
		send_text("ab", 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h00, 1'b0);
		// no length header, cr cr lf ahead of the blank line
		send_text("GET", 1'b1);
		send_byte(CHAR_CR, 1'b0);
		send_crlf();
		send_crlf();
		// name inside a longer one with no digits, later match ignored
		send_text("x-content-length: q", 1'b1);
		send_crlf();
		send_text("content-length: 9", 1'b0);
		send_crlf();
		send_crlf();
		send_byte(8'h40, 1'b0);
	endtask

	task automatic test_length_limits();
		set_max_length(24'd1);
		send_text("content-length:1", 1'b1);
		send_crlf();
		send_crlf();
		send_text("z", 1'b0);
		send_text("content-length:10", 1'b1);
		send_crlf();
		send_crlf();
		set_max_length(24'hffffff);
		send_text("content-length:16777215", 1'b1);
		send_crlf();
		send_crlf();
		send_text("content-length: 16777216", 1'b1);
		send_crlf();
		send_crlf();
	endtask

	task automatic test_backlog_drain();
		send_text("content-length: 2", 1'b1);
		send_crlf();
		settle();
		send_crlf();
		send_text("ab", 1'b0);
		settle();
	endtask

	task automatic test_random_traffic();
		logic [23:0] limits [5];
		int          target;
		limits[0] = MAX_LENGTH_RESET;
		limits[1] = 24'hffffff;
		limits[2] = 24'd1;
		limits[3] = 24'($urandom_range(2, 99999));
		limits[4] = 24'd20;
		for (int p = 0; p < 5; p++) begin
			set_max_length(limits[p]);
			// last phase runs with no idling on either side
			if (p == 4)
				gaps_on = 1'b0;
			target = bytes_sent + 280;
			while (bytes_sent < target) begin
				if ($urandom_range(0, 24) == 0)
					settle();
				send_random_request();
			end
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		cfg_we   = 1'b0;
		cfg_data = 24'd0;
		s_tvalid = 1'b0;
		s_tdata  = 8'd0;
		s_tuser  = 1'b0;
		clear_tracker();
		max_len = MAX_LENGTH_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_requests();
		test_length_limits();
		test_backlog_drain();
		test_random_traffic();

		settle();
		repeat (8) @(posedge clk);
		if (err_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
